/* sv/btu_pkg.sv */
// shared types and constants for the bit timed 8n1 uart
package btu_pkg;

   localparam int unsigned  TICK_W         = 16;
   localparam int unsigned  RX_TIMER_W     = 20;
   localparam int unsigned  CSR_ADDR_W     = 3;
   localparam int unsigned  CSR_DATA_W     = 32;

   localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 16'd104;
   localparam logic [3:0]        FRAME_BITS      = 4'd10;
   localparam logic [3:0]        DATA_BITS       = 4'd8;
   localparam logic              REG_BIT_TICKS   = 1'b0;

   typedef enum logic [1:0] {
      RX_IDLE = 2'd0,
      RX_WAIT = 2'd1,
      RX_RECV = 2'd2
   } rx_phase_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_out_type;

   typedef struct packed {
      logic       busy;
      logic       valid;
      logic [7:0] data;
      logic       timeout;
   } rx_out_type;

endpackage

/* sv/bit_timed_uart_8n1.sv */
// top level of the bit timed 8n1 uart
//
// every req item is one tick: it carries the sampled receive line, a transmit
// request with its byte and a receive arm request. every accepted item yields
// exactly one rsp item with the transmit line level, both busy flags, a
// received byte strobe with its data and a start bit timeout strobe.
// an item accepted at one edge appears on rsp in the next cycle. while
// req_stall is low one item is taken every cycle, the state update being a
// single registered pass. the rsp register holds while rsp_stall is high, and
// req_stall rises only when that register is full and stalled, so a taken item
// frees a slot for the next one in the same cycle.
// bit_ticks (csr address 0) sets ticks per serial bit, 104 after reset; a
// value of 0 acts as 1. write it only while both directions are idle.
// reset clears both directions to idle, line high, and empties the rsp
// register.
module bit_timed_uart_8n1 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_rx_line,
   input  logic                               req_tx_start,
   input  logic [7:0]                         req_tx_byte,
   input  logic                               req_rx_arm,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_tx_line,
   output logic                               rsp_tx_busy,
   output logic                               rsp_rx_busy,
   output logic                               rsp_rx_valid,
   output logic [7:0]                         rsp_rx_byte,
   output logic                               rsp_rx_timeout,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [btu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [btu_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [btu_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [btu_pkg::TICK_W-1:0]  bit_ticks_ff, bit_ticks_in;
   logic [btu_pkg::TICK_W-1:0]  eff_ticks;
   logic                        csr_write;
   logic                        accept;

   btu_pkg::tx_out_type         tx_out;
   btu_pkg::rx_out_type         rx_out;

   logic                        rsp_valid_ff, rsp_valid_in;
   btu_pkg::tx_out_type         rsp_tx_ff;
   btu_pkg::rx_out_type         rsp_rx_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == btu_pkg::REG_BIT_TICKS);
   assign csr_prdata = (csr_paddr[2] == btu_pkg::REG_BIT_TICKS)
                       ? btu_pkg::CSR_DATA_W'(bit_ticks_ff) : '0;
   assign bit_ticks_in = csr_write ? csr_pwdata[btu_pkg::TICK_W-1:0] : bit_ticks_ff;
   assign eff_ticks    = (bit_ticks_ff == '0) ? btu_pkg::TICK_W'(1) : bit_ticks_ff;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   btu_tx u_tx (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .bit_ticks (eff_ticks),
      .tx_start  (req_tx_start),
      .tx_byte   (req_tx_byte),
      .tx_out    (tx_out)
   );

   btu_rx u_rx (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .bit_ticks (eff_ticks),
      .rx_line   (req_rx_line),
      .rx_arm    (req_rx_arm),
      .rx_out    (rx_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= btu_pkg::BIT_TICKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bit_ticks_ff <= bit_ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tx_ff <= tx_out;
         rsp_rx_ff <= rx_out;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_line    = rsp_tx_ff.line;
   assign rsp_tx_busy    = rsp_tx_ff.busy;
   assign rsp_rx_busy    = rsp_rx_ff.busy;
   assign rsp_rx_valid   = rsp_rx_ff.valid;
   assign rsp_rx_byte    = rsp_rx_ff.data;
   assign rsp_rx_timeout = rsp_rx_ff.timeout;

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !accept)
      else $error("item taken while rsp register full and stalled");

   a_rx_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_rx_ff.valid || rsp_rx_ff.timeout)) |-> !rsp_rx_ff.busy)
      else $error("receiver busy after byte or timeout");

   a_rx_strobe_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_rx_ff.valid && rsp_rx_ff.timeout))
      else $error("byte and timeout on the same tick");

   a_tx_idle_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tx_ff.busy) |-> rsp_tx_ff.line)
      else $error("tx line low while transmitter idle");

endmodule

/* sv/btu_tx.sv */
// transmit framer: start bit, eight data bits lsb first, stop bit
module btu_tx (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [btu_pkg::TICK_W-1:0]     bit_ticks,
   input  logic                           tx_start,
   input  logic [7:0]                     tx_byte,
   output btu_pkg::tx_out_type            tx_out
);

   logic                        active_ff, active_in;
   logic [3:0]                  idx_ff, idx_in;
   logic [btu_pkg::TICK_W-1:0]  timer_ff, timer_in;
   logic [7:0]                  shift_ff, shift_in;

   logic                        load;
   logic                        act;
   logic [3:0]                  idx_cur;
   logic [3:0]                  idx_inc;
   logic [7:0]                  shift_cur;
   logic [btu_pkg::TICK_W:0]    timer_inc;
   logic [2:0]                  bit_sel;

   assign load      = !active_ff && tx_start;
   assign act       = active_ff || load;
   assign idx_cur   = load ? 4'd0 : idx_ff;
   assign idx_inc   = idx_cur + 4'd1;
   assign shift_cur = load ? tx_byte : shift_ff;
   assign timer_inc = (load ? {(btu_pkg::TICK_W+1){1'b0}} : {1'b0, timer_ff})
                      + {{btu_pkg::TICK_W{1'b0}}, 1'b1};
   assign bit_sel   = 3'(idx_cur - 4'd1);

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      timer_in  = timer_ff;
      shift_in  = shift_cur;
      if (act) begin
         active_in = 1'b1;
         if (timer_inc >= {1'b0, bit_ticks}) begin
            timer_in = '0;
            if (idx_inc >= btu_pkg::FRAME_BITS) begin
               idx_in    = 4'd0;
               active_in = 1'b0;
            end else begin
               idx_in = idx_inc;
            end
         end else begin
            timer_in = timer_inc[btu_pkg::TICK_W-1:0];
            idx_in   = idx_cur;
         end
      end
   end

   always_comb begin
      tx_out.busy = act;
      tx_out.line = 1'b1;
      if (act) begin
         if (idx_cur == 4'd0) begin
            tx_out.line = 1'b0;
         end else if (idx_cur <= btu_pkg::DATA_BITS) begin
            tx_out.line = shift_cur[bit_sel];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 4'd0;
         timer_ff  <= '0;
         shift_ff  <= 8'd0;
      end else if (step) begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         timer_ff  <= timer_in;
         shift_ff  <= shift_in;
      end
   end

endmodule

/* sv/btu_rx.sv */
// receive sampler with start bit wait and timeout
module btu_rx (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [btu_pkg::TICK_W-1:0]     bit_ticks,
   input  logic                           rx_line,
   input  logic                           rx_arm,
   output btu_pkg::rx_out_type            rx_out
);

   localparam int unsigned TW = btu_pkg::RX_TIMER_W;

   btu_pkg::rx_phase_type  phase_ff, phase_in, phase_cur;
   logic [TW-1:0]          timer_ff, timer_in;
   logic [3:0]             idx_ff, idx_in;
   logic [7:0]             shift_ff, shift_in;

   logic                   arming;
   logic [TW-1:0]          timer_cur;
   logic [TW-1:0]          timer_inc;
   logic [TW-1:0]          bt_w;
   logic [TW-1:0]          wait_limit;
   logic [TW-1:0]          target;
   logic                   sample_due;

   assign arming     = (phase_ff == btu_pkg::RX_IDLE) && rx_arm;
   assign phase_cur  = arming ? btu_pkg::RX_WAIT : phase_ff;
   assign timer_cur  = arming ? '0 : timer_ff;
   assign timer_inc  = timer_cur + {{(TW-1){1'b0}}, 1'b1};
   assign bt_w       = TW'(bit_ticks);
   assign wait_limit = (bt_w << 3) + (bt_w << 1);
   assign target     = bt_w + (bt_w >> 1) + (bt_w * TW'(idx_ff));
   assign sample_due = timer_inc >= target;

   always_comb begin
      phase_in = phase_cur;
      timer_in = timer_cur;
      idx_in   = idx_ff;
      shift_in = shift_ff;
      case (phase_cur)
         btu_pkg::RX_IDLE: begin
            phase_in = btu_pkg::RX_IDLE;
         end
         btu_pkg::RX_WAIT: begin
            if (!rx_line) begin
               phase_in = btu_pkg::RX_RECV;
               timer_in = '0;
               idx_in   = 4'd0;
               shift_in = 8'd0;
            end else if (timer_cur > wait_limit) begin
               phase_in = btu_pkg::RX_IDLE;
               timer_in = '0;
            end else begin
               timer_in = timer_inc;
            end
         end
         btu_pkg::RX_RECV: begin
            timer_in = timer_inc;
            if (sample_due) begin
               if (idx_ff < btu_pkg::DATA_BITS) begin
                  shift_in = {rx_line, shift_ff[7:1]};
                  idx_in   = idx_ff + 4'd1;
               end else begin
                  phase_in = btu_pkg::RX_IDLE;
                  timer_in = '0;
                  idx_in   = 4'd0;
               end
            end
         end
         default: begin
            phase_in = btu_pkg::RX_IDLE;
         end
      endcase
   end

   always_comb begin
      rx_out.busy    = (phase_in != btu_pkg::RX_IDLE);
      rx_out.valid   = 1'b0;
      rx_out.data    = 8'd0;
      rx_out.timeout = 1'b0;
      case (phase_cur)
         btu_pkg::RX_WAIT: begin
            rx_out.timeout = rx_line && (timer_cur > wait_limit);
         end
         btu_pkg::RX_RECV: begin
            if (sample_due && !(idx_ff < btu_pkg::DATA_BITS)) begin
               rx_out.valid = 1'b1;
               rx_out.data  = shift_ff;
            end
         end
         default: begin
            rx_out.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= btu_pkg::RX_IDLE;
         timer_ff <= '0;
         idx_ff   <= 4'd0;
         shift_ff <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         idx_ff   <= idx_in;
         shift_ff <= shift_in;
      end
   end

endmodule
